@@ rtl/core/nab_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package nab_pkg;

    // Command codes
    localparam logic [4:0] CMD_LDA = 5'd0;
    localparam logic [4:0] CMD_LDX = 5'd1;
    localparam logic [4:0] CMD_LDY = 5'd2;
    localparam logic [4:0] CMD_AND = 5'd3;
    localparam logic [4:0] CMD_ORA = 5'd4;
    localparam logic [4:0] CMD_EOR = 5'd5;
    localparam logic [4:0] CMD_BIT = 5'd6;
    localparam logic [4:0] CMD_ADC = 5'd7;
    localparam logic [4:0] CMD_SBC = 5'd8;
    localparam logic [4:0] CMD_CMP = 5'd9;
    localparam logic [4:0] CMD_CPX = 5'd10;
    localparam logic [4:0] CMD_CPY = 5'd11;
    localparam logic [4:0] CMD_AXS = 5'd12;
    localparam logic [4:0] CMD_INC = 5'd13;
    localparam logic [4:0] CMD_DEC = 5'd14;
    localparam logic [4:0] CMD_ASL = 5'd15;
    localparam logic [4:0] CMD_LSR = 5'd16;
    localparam logic [4:0] CMD_ROL = 5'd17;
    localparam logic [4:0] CMD_ROR = 5'd18;

    // Status bit positions
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef struct packed {
        logic [4:0] command;
        logic [7:0] acc_in;
        logic [7:0] xreg_in;
        logic [7:0] yreg_in;
        logic [7:0] operand;
        logic [7:0] status_in;
    } t_alu_in;

    typedef struct packed {
        logic [7:0] acc_out;
        logic [7:0] xreg_out;
        logic [7:0] yreg_out;
        logic [7:0] mem_out;
        logic [7:0] status_out;
    } t_alu_out;

    // Decoded per-item control, carried down the pipe
    typedef struct packed {
        logic wr_a;
        logic wr_x;
        logic wr_y;
        logic wr_m;
        logic use_sum;   // result byte comes from the adder
        logic upd_zn;
        logic upd_c;
        logic v_adc;
        logic v_sbc;
        logic is_bit;
    } t_ctl;

endpackage

`default_nettype wire

@@ rtl/core/nab_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface nab_in_if;
    logic               valid;
    logic               ready;
    nab_pkg::t_alu_in   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface nab_out_if;
    logic               valid;
    logic               ready;
    nab_pkg::t_alu_out  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/core/nmos6502_alu_binary_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake     Payload
// i_in      in   valid/ready   command, acc_in, xreg_in, yreg_in, operand, status_in
// o_out     out  valid/ready   acc_out, xreg_out, yreg_out, mem_out, status_out
//
// Four register stages: input capture (A), decode + logic/shift (B),
// 9-bit add (C), flag merge into the output register (D).
// One item per cycle sustained while o_out.ready stays high; an item passes stages A, B, C and D in order.
// Each stage takes a new item when it is empty or its successor moves, so
// bubbles collapse and a stall on o_out holds every item in place.
// Synchronous active-low reset clears only the stage valid bits.

module nmos6502_alu_binary_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    nab_in_if.sink      i_in,
    nab_out_if.source   o_out
);

    // Stage valid bits and advance enables
    logic r_vld_a, r_vld_b, r_vld_c, r_vld_d;
    logic rdy_a, rdy_b, rdy_c, rdy_d;

    assign rdy_d = !r_vld_d || o_out.ready;
    assign rdy_c = !r_vld_c || rdy_d;
    assign rdy_b = !r_vld_b || rdy_c;
    assign rdy_a = !r_vld_a || rdy_b;

    assign i_in.ready = rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else begin
            if (rdy_a) r_vld_a <= i_in.valid;
            if (rdy_b) r_vld_b <= r_vld_a;
            if (rdy_c) r_vld_c <= r_vld_b;
            if (rdy_d) r_vld_d <= r_vld_c;
        end
    end

    // ---------------- Stage A: capture ----------------
    nab_pkg::t_alu_in r_item_a;

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_in.valid) r_item_a <= i_in.payload;
    end

    // ---------------- Decode, logic and shifts ----------------
    nab_pkg::t_ctl n_ctl;
    logic [7:0]    n_lres;     // non-adder result byte
    logic          n_lcout;    // carry shifted out
    logic [7:0]    n_add_x;
    logic [7:0]    n_add_y;
    logic          n_add_c;

    always_comb begin
        logic [7:0] a, x, y, m;
        logic       cin;
        a   = r_item_a.acc_in;
        x   = r_item_a.xreg_in;
        y   = r_item_a.yreg_in;
        m   = r_item_a.operand;
        cin = r_item_a.status_in[nab_pkg::FLAG_C];

        n_ctl   = '0;
        n_lres  = m;
        n_lcout = 1'b0;
        n_add_x = a;
        n_add_y = m;
        n_add_c = 1'b0;

        case (r_item_a.command)
            nab_pkg::CMD_LDA: begin
                n_ctl.wr_a = 1'b1; n_ctl.upd_zn = 1'b1;
            end
            nab_pkg::CMD_LDX: begin
                n_ctl.wr_x = 1'b1; n_ctl.upd_zn = 1'b1;
            end
            nab_pkg::CMD_LDY: begin
                n_ctl.wr_y = 1'b1; n_ctl.upd_zn = 1'b1;
            end
            nab_pkg::CMD_AND: begin
                n_lres = a & m; n_ctl.wr_a = 1'b1; n_ctl.upd_zn = 1'b1;
            end
            nab_pkg::CMD_ORA: begin
                n_lres = a | m; n_ctl.wr_a = 1'b1; n_ctl.upd_zn = 1'b1;
            end
            nab_pkg::CMD_EOR: begin
                n_lres = a ^ m; n_ctl.wr_a = 1'b1; n_ctl.upd_zn = 1'b1;
            end
            nab_pkg::CMD_BIT: begin
                n_lres = a & m; n_ctl.is_bit = 1'b1;
            end
            nab_pkg::CMD_ADC: begin
                n_add_c = cin;
                n_ctl.wr_a = 1'b1; n_ctl.use_sum = 1'b1; n_ctl.upd_zn = 1'b1;
                n_ctl.upd_c = 1'b1; n_ctl.v_adc = 1'b1;
            end
            nab_pkg::CMD_SBC: begin
                n_add_y = ~m; n_add_c = cin;
                n_ctl.wr_a = 1'b1; n_ctl.use_sum = 1'b1; n_ctl.upd_zn = 1'b1;
                n_ctl.upd_c = 1'b1; n_ctl.v_sbc = 1'b1;
            end
            nab_pkg::CMD_CMP: begin
                n_add_y = ~m; n_add_c = 1'b1;
                n_ctl.use_sum = 1'b1; n_ctl.upd_zn = 1'b1; n_ctl.upd_c = 1'b1;
            end
            nab_pkg::CMD_CPX: begin
                n_add_x = x; n_add_y = ~m; n_add_c = 1'b1;
                n_ctl.use_sum = 1'b1; n_ctl.upd_zn = 1'b1; n_ctl.upd_c = 1'b1;
            end
            nab_pkg::CMD_CPY: begin
                n_add_x = y; n_add_y = ~m; n_add_c = 1'b1;
                n_ctl.use_sum = 1'b1; n_ctl.upd_zn = 1'b1; n_ctl.upd_c = 1'b1;
            end
            nab_pkg::CMD_AXS: begin
                n_add_x = a & x; n_add_y = ~m; n_add_c = 1'b1;
                n_ctl.wr_x = 1'b1;
                n_ctl.use_sum = 1'b1; n_ctl.upd_zn = 1'b1; n_ctl.upd_c = 1'b1;
            end
            nab_pkg::CMD_INC: begin
                n_add_x = m; n_add_y = 8'h00; n_add_c = 1'b1;
                n_ctl.wr_m = 1'b1; n_ctl.use_sum = 1'b1; n_ctl.upd_zn = 1'b1;
            end
            nab_pkg::CMD_DEC: begin
                n_add_x = m; n_add_y = nab_pkg::BYTE_ONES; n_add_c = 1'b0;
                n_ctl.wr_m = 1'b1; n_ctl.use_sum = 1'b1; n_ctl.upd_zn = 1'b1;
            end
            nab_pkg::CMD_ASL: begin
                n_lres = {m[6:0], 1'b0}; n_lcout = m[7];
                n_ctl.wr_m = 1'b1; n_ctl.upd_zn = 1'b1; n_ctl.upd_c = 1'b1;
            end
            nab_pkg::CMD_LSR: begin
                n_lres = {1'b0, m[7:1]}; n_lcout = m[0];
                n_ctl.wr_m = 1'b1; n_ctl.upd_zn = 1'b1; n_ctl.upd_c = 1'b1;
            end
            nab_pkg::CMD_ROL: begin
                n_lres = {m[6:0], cin}; n_lcout = m[7];
                n_ctl.wr_m = 1'b1; n_ctl.upd_zn = 1'b1; n_ctl.upd_c = 1'b1;
            end
            nab_pkg::CMD_ROR: begin
                n_lres = {cin, m[7:1]}; n_lcout = m[0];
                n_ctl.wr_m = 1'b1; n_ctl.upd_zn = 1'b1; n_ctl.upd_c = 1'b1;
            end
            default: begin
                // undefined codes: everything passes through
                n_ctl = '0;
            end
        endcase
    end

    // ---------------- Stage B ----------------
    nab_pkg::t_alu_in r_item_b;
    nab_pkg::t_ctl    r_ctl_b;
    logic [7:0]       r_lres_b;
    logic             r_lcout_b;
    logic [7:0]       r_add_x_b;
    logic [7:0]       r_add_y_b;
    logic             r_add_c_b;

    always_ff @(posedge i_clk) begin
        if (rdy_b && r_vld_a) begin
            r_item_b  <= r_item_a;
            r_ctl_b   <= n_ctl;
            r_lres_b  <= n_lres;
            r_lcout_b <= n_lcout;
            r_add_x_b <= n_add_x;
            r_add_y_b <= n_add_y;
            r_add_c_b <= n_add_c;
        end
    end

    // 9-bit add; bit 8 is carry out (not-borrow for subtracts)
    logic [8:0] n_sum;
    assign n_sum = {1'b0, r_add_x_b} + {1'b0, r_add_y_b} + {8'h00, r_add_c_b};

    // ---------------- Stage C ----------------
    nab_pkg::t_alu_in r_item_c;
    nab_pkg::t_ctl    r_ctl_c;
    logic [7:0]       r_lres_c;
    logic             r_lcout_c;
    logic [8:0]       r_sum_c;

    always_ff @(posedge i_clk) begin
        if (rdy_c && r_vld_b) begin
            r_item_c  <= r_item_b;
            r_ctl_c   <= r_ctl_b;
            r_lres_c  <= r_lres_b;
            r_lcout_c <= r_lcout_b;
            r_sum_c   <= n_sum;
        end
    end

    // ---------------- Flag merge and write select ----------------
    nab_pkg::t_alu_out n_out;

    always_comb begin
        logic [7:0] res, a, m, p;
        a   = r_item_c.acc_in;
        m   = r_item_c.operand;
        res = r_ctl_c.use_sum ? r_sum_c[7:0] : r_lres_c;
        p   = r_item_c.status_in;

        if (r_ctl_c.upd_zn) begin
            p[nab_pkg::FLAG_Z] = (res == 8'h00);
            p[nab_pkg::FLAG_N] = res[7];
        end
        if (r_ctl_c.is_bit) begin
            // Z from A AND M, V and N straight from the operand
            p[nab_pkg::FLAG_Z] = (res == 8'h00);
            p[nab_pkg::FLAG_V] = m[6];
            p[nab_pkg::FLAG_N] = m[7];
        end
        if (r_ctl_c.upd_c) begin
            p[nab_pkg::FLAG_C] = r_ctl_c.use_sum ? r_sum_c[8] : r_lcout_c;
        end
        if (r_ctl_c.v_adc) begin
            p[nab_pkg::FLAG_V] = ~(a[7] ^ m[7]) & (a[7] ^ res[7]);
        end
        if (r_ctl_c.v_sbc) begin
            p[nab_pkg::FLAG_V] = (a[7] ^ res[7]) & (a[7] ^ m[7]);
        end

        n_out.acc_out    = r_ctl_c.wr_a ? res : a;
        n_out.xreg_out   = r_ctl_c.wr_x ? res : r_item_c.xreg_in;
        n_out.yreg_out   = r_ctl_c.wr_y ? res : r_item_c.yreg_in;
        n_out.mem_out    = r_ctl_c.wr_m ? res : m;
        n_out.status_out = p;
    end

    // ---------------- Stage D: output register ----------------
    nab_pkg::t_alu_out r_out_d;

    always_ff @(posedge i_clk) begin
        if (rdy_d && r_vld_c) r_out_d <= n_out;
    end

    assign o_out.valid   = r_vld_d;
    assign o_out.payload = r_out_d;

endmodule

`default_nettype wire

@@ verif/tb_nmos6502_alu_binary_unit.sv @@
`timescale 1ns / 1ps

module tb_nmos6502_alu_binary_unit;

    // Codes 19..31 are not decoded: the block must pass everything through.
    localparam logic [4:0] CMD_FIRST_UNDEF = nab_pkg::CMD_ROR + 5'd1;
    localparam logic [4:0] CMD_LAST_UNDEF  = 5'h1F;

    localparam int RANDOM_OPS   = 650;
    // The slowest correct run covers about 700 items with idle gaps on both sides.
    // The limit allows several times its length.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;       // 4-stage pipe plus margin

    logic clk;
    logic rst_n;

    nab_in_if  alu_in ();
    nab_out_if alu_out ();

    nmos6502_alu_binary_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (alu_in),
        .o_out   (alu_out)
    );

    nab_pkg::t_alu_in  byte_ops_q[$];      // items not yet offered to the block
    nab_pkg::t_alu_out alu_results_q[$];   // predicted results, oldest first

    int accepted_count = 0;
    int result_count   = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_wait      = 0;
    int recv_stall     = 0;

    // 2 ns clock
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Predictor: one ALU operation, flags per NMOS 6502 binary mode.
    // Flags a command does not touch are copied from status_in, and D is
    // never looked at.
    // ------------------------------------------------------------------
    function automatic nab_pkg::t_alu_out predict_alu(input nab_pkg::t_alu_in op);
        nab_pkg::t_alu_out res;
        logic [8:0] wide;
        logic [7:0] zn_byte;
        logic [7:0] cmp_reg;
        logic       carry_in;
        logic       upd_zn;
        logic       do_cmp;

        res.acc_out    = op.acc_in;
        res.xreg_out   = op.xreg_in;
        res.yreg_out   = op.yreg_in;
        res.mem_out    = op.operand;
        res.status_out = op.status_in;
        carry_in       = op.status_in[nab_pkg::FLAG_C];
        upd_zn         = 1'b1;
        do_cmp         = 1'b0;
        cmp_reg        = '0;
        zn_byte        = '0;
        wide           = '0;

        case (op.command)
            nab_pkg::CMD_LDA: begin
                res.acc_out = op.operand;
                zn_byte     = res.acc_out;
            end
            nab_pkg::CMD_LDX: begin
                res.xreg_out = op.operand;
                zn_byte      = res.xreg_out;
            end
            nab_pkg::CMD_LDY: begin
                res.yreg_out = op.operand;
                zn_byte      = res.yreg_out;
            end
            nab_pkg::CMD_AND: begin
                res.acc_out = op.acc_in & op.operand;
                zn_byte     = res.acc_out;
            end
            nab_pkg::CMD_ORA: begin
                res.acc_out = op.acc_in | op.operand;
                zn_byte     = res.acc_out;
            end
            nab_pkg::CMD_EOR: begin
                res.acc_out = op.acc_in ^ op.operand;
                zn_byte     = res.acc_out;
            end
            nab_pkg::CMD_BIT: begin
                // Z from A AND M; V and N come straight from the operand.
                upd_zn = 1'b0;
                res.status_out[nab_pkg::FLAG_Z] = ((op.acc_in & op.operand) == 8'h00);
                res.status_out[nab_pkg::FLAG_V] = op.operand[6];
                res.status_out[nab_pkg::FLAG_N] = op.operand[7];
            end
            nab_pkg::CMD_ADC: begin
                wide = {1'b0, op.acc_in} + {1'b0, op.operand} + {8'h00, carry_in};
                // Overflow: both operands of one sign, sum of the other sign
                res.status_out[nab_pkg::FLAG_V] = ~(op.acc_in[7] ^ op.operand[7])
                                                  & (op.acc_in[7] ^ wide[7]);
                res.status_out[nab_pkg::FLAG_C] = wide[8];
                res.acc_out                     = wide[7:0];
                zn_byte                         = wide[7:0];
            end
            nab_pkg::CMD_SBC: begin
                // Borrow is the inverted carry; C out is the inverted borrow.
                wide = {1'b0, op.acc_in} - {1'b0, op.operand} - {8'h00, ~carry_in};
                res.status_out[nab_pkg::FLAG_V] = (op.acc_in[7] ^ wide[7])
                                                  & (op.acc_in[7] ^ op.operand[7]);
                res.status_out[nab_pkg::FLAG_C] = ~wide[8];
                res.acc_out                     = wide[7:0];
                zn_byte                         = wide[7:0];
            end
            nab_pkg::CMD_CMP: begin
                do_cmp  = 1'b1;
                cmp_reg = op.acc_in;
            end
            nab_pkg::CMD_CPX: begin
                do_cmp  = 1'b1;
                cmp_reg = op.xreg_in;
            end
            nab_pkg::CMD_CPY: begin
                do_cmp  = 1'b1;
                cmp_reg = op.yreg_in;
            end
            nab_pkg::CMD_AXS: begin
                // Compare (A AND X) against M; the difference lands in X.
                do_cmp  = 1'b1;
                cmp_reg = op.acc_in & op.xreg_in;
            end
            nab_pkg::CMD_INC: begin
                res.mem_out = op.operand + 8'd1;
                zn_byte     = res.mem_out;
            end
            nab_pkg::CMD_DEC: begin
                res.mem_out = op.operand - 8'd1;
                zn_byte     = res.mem_out;
            end
            nab_pkg::CMD_ASL: begin
                res.status_out[nab_pkg::FLAG_C] = op.operand[7];
                res.mem_out                     = {op.operand[6:0], 1'b0};
                zn_byte                         = res.mem_out;
            end
            nab_pkg::CMD_LSR: begin
                res.status_out[nab_pkg::FLAG_C] = op.operand[0];
                res.mem_out                     = {1'b0, op.operand[7:1]};
                zn_byte                         = res.mem_out;
            end
            nab_pkg::CMD_ROL: begin
                res.status_out[nab_pkg::FLAG_C] = op.operand[7];
                res.mem_out                     = {op.operand[6:0], carry_in};
                zn_byte                         = res.mem_out;
            end
            nab_pkg::CMD_ROR: begin
                res.status_out[nab_pkg::FLAG_C] = op.operand[0];
                res.mem_out                     = {carry_in, op.operand[7:1]};
                zn_byte                         = res.mem_out;
            end
            default: begin
                upd_zn = 1'b0;   // undecoded: pure pass-through
            end
        endcase

        if (do_cmp) begin
            // No borrow out of the 9-bit difference means reg >= operand.
            wide                            = {1'b0, cmp_reg} - {1'b0, op.operand};
            res.status_out[nab_pkg::FLAG_C] = ~wide[8];
            zn_byte                         = wide[7:0];
            if (op.command == nab_pkg::CMD_AXS) begin
                res.xreg_out = wide[7:0];
            end
        end

        if (upd_zn) begin
            res.status_out[nab_pkg::FLAG_Z] = (zn_byte == 8'h00);
            res.status_out[nab_pkg::FLAG_N] = zn_byte[7];
        end
        return res;
    endfunction

    // Idle pattern changes every few dozen items: none, full range, sparse.
    function automatic int draw_wait(input int phase);
        case (phase % 3)
            0:       return 0;
            1:       return $urandom_range(0, 11);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
        endcase
    endfunction

    // Random byte biased toward the corner values.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return nab_pkg::BYTE_ONES;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_op(input logic [4:0] cmd, input logic [7:0] a, input logic [7:0] x,
                            input logic [7:0] y, input logic [7:0] m, input logic [7:0] p);
        nab_pkg::t_alu_in op;
        op.command   = cmd;
        op.acc_in    = a;
        op.xreg_in   = x;
        op.yreg_in   = y;
        op.operand   = m;
        op.status_in = p;
        byte_ops_q.push_back(op);
    endtask

    task automatic check_byte(input string field, input logic [7:0] want,
                              input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %02h, got %02h", field, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver.
    //   - A new item goes out only when the slot is empty or the current
    //     one was just taken, so valid never drops while an item is waiting.
    //   - The prediction is made at the edge the block accepts the item.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            alu_in.valid <= 1'b0;
        end else begin
            if (alu_in.valid && alu_in.ready) begin
                alu_results_q.push_back(predict_alu(alu_in.payload));
                accepted_count++;
            end
            if (!alu_in.valid || alu_in.ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    alu_in.valid <= 1'b0;
                end else if (byte_ops_q.size() > 0) begin
                    alu_in.payload <= byte_ops_q.pop_front();
                    alu_in.valid   <= 1'b1;
                    send_wait = draw_wait(accepted_count / 60);
                end else begin
                    alu_in.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor.
    //   - Ready is held low for a drawn stall count after each accepted result.
    //   - The stall period differs from the driver's so that the two
    //     idle patterns drift against each other.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        nab_pkg::t_alu_out want;
        if (!rst_n) begin
            alu_out.ready <= 1'b0;
        end else begin
            if (alu_out.valid && alu_out.ready) begin
                result_count++;
                if (alu_results_q.size() == 0) begin
                    $error("result with no item outstanding: %h", alu_out.payload);
                    mismatch_count++;
                end else begin
                    want = alu_results_q.pop_front();
                    check_byte("acc_out",    want.acc_out,    alu_out.payload.acc_out);
                    check_byte("xreg_out",   want.xreg_out,   alu_out.payload.xreg_out);
                    check_byte("yreg_out",   want.yreg_out,   alu_out.payload.yreg_out);
                    check_byte("mem_out",    want.mem_out,    alu_out.payload.mem_out);
                    check_byte("status_out", want.status_out, alu_out.payload.status_out);
                end
                recv_stall = draw_wait(result_count / 45 + 1);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                alu_out.ready <= 1'b0;
            end else begin
                alu_out.ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("nmos6502_alu_binary_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ------------------------------------------------------------------
    initial begin
        nab_pkg::t_alu_in op;
        int               defined_ops;

        rst_n       = 1'b0;
        defined_ops = 0;

        // Directed corners
        // (arguments: cmd, A, X, Y, M, P)
        queue_op(nab_pkg::CMD_LDA, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h80);  // load zero -> Z
        queue_op(nab_pkg::CMD_LDX, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h02);  // negative load
        queue_op(nab_pkg::CMD_LDY, 8'h00, 8'h00, 8'h00, nab_pkg::BYTE_ONES, 8'hFF);
        queue_op(nab_pkg::CMD_AND, nab_pkg::BYTE_ONES, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_op(nab_pkg::CMD_ORA, 8'h80, 8'h00, 8'h00, 8'h7F, 8'h02);
        queue_op(nab_pkg::CMD_EOR, nab_pkg::BYTE_ONES, 8'h00, 8'h00, nab_pkg::BYTE_ONES,
                 8'h80);
        queue_op(nab_pkg::CMD_BIT, 8'h01, 8'h00, 8'h00, 8'hC0, 8'h00);  // Z with V,N from M
        queue_op(nab_pkg::CMD_ADC, 8'h7F, 8'h00, 8'h00, 8'h01, 8'h00);  // signed overflow
        queue_op(nab_pkg::CMD_ADC, nab_pkg::BYTE_ONES, 8'h00, 8'h00, 8'h01,
                 8'h01);                                                // carry out
        queue_op(nab_pkg::CMD_ADC, 8'h80, 8'h00, 8'h00, 8'h80, 8'h08);  // V, C, Z; D set
        queue_op(nab_pkg::CMD_SBC, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01);  // borrow
        queue_op(nab_pkg::CMD_SBC, 8'h80, 8'h00, 8'h00, 8'h01, 8'h09);  // overflow, D set
        queue_op(nab_pkg::CMD_SBC, 8'h50, 8'h00, 8'h00, 8'h50, 8'h00);  // borrow in
        queue_op(nab_pkg::CMD_CMP, 8'h40, 8'h00, 8'h00, 8'h40, 8'h00);  // equal
        queue_op(nab_pkg::CMD_CPX, 8'h00, 8'h00, 8'h00, nab_pkg::BYTE_ONES,
                 8'hFF);                                                // reg < operand
        queue_op(nab_pkg::CMD_CPY, 8'h00, 8'h00, nab_pkg::BYTE_ONES, 8'h00, 8'h00);
        queue_op(nab_pkg::CMD_AXS, 8'hF0, 8'h3C, 8'h00, 8'h10, 8'h00);
        queue_op(nab_pkg::CMD_INC, 8'h00, 8'h00, 8'h00, nab_pkg::BYTE_ONES,
                 8'h80);                                                // wrap to zero
        queue_op(nab_pkg::CMD_DEC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02);  // wrap to FF
        queue_op(nab_pkg::CMD_ASL, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00);
        queue_op(nab_pkg::CMD_LSR, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80);
        queue_op(nab_pkg::CMD_ROL, 8'h00, 8'h00, 8'h00, 8'h80, 8'h01);  // carry rotates in
        queue_op(nab_pkg::CMD_ROR, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00);
        queue_op(CMD_FIRST_UNDEF, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A);
        queue_op(CMD_LAST_UNDEF, nab_pkg::BYTE_ONES, nab_pkg::BYTE_ONES, nab_pkg::BYTE_ONES,
                 nab_pkg::BYTE_ONES, nab_pkg::BYTE_ONES);

        // Random part; undecoded commands are sprinkled in but not counted.
        while (defined_ops < RANDOM_OPS) begin
            if ($urandom_range(0, 19) == 0) begin
                op.command = 5'($urandom_range(int'(CMD_FIRST_UNDEF), int'(CMD_LAST_UNDEF)));
            end else begin
                op.command = 5'($urandom_range(int'(nab_pkg::CMD_LDA),
                                               int'(nab_pkg::CMD_ROR)));
                defined_ops++;
            end
            op.acc_in    = pick_byte();
            op.xreg_in   = pick_byte();
            op.yreg_in   = pick_byte();
            op.operand   = pick_byte();
            op.status_in = 8'($urandom);
            // equal compares and AXS yielding zero need operand == register
            case ($urandom_range(0, 11))
                0:       op.operand = op.acc_in;
                1:       op.operand = op.xreg_in;
                2:       op.operand = op.yreg_in;
                3:       op.operand = op.acc_in & op.xreg_in;
                default: ;
            endcase
            byte_ops_q.push_back(op);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: everything sent, everything answered
        do begin
            @(negedge clk);
        end while (byte_ops_q.size() != 0 || alu_in.valid || alu_results_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && alu_results_q.size() == 0) begin
            $display("nmos6502_alu_binary_unit verification clean");
        end else begin
            $display("nmos6502_alu_binary_unit verification failed");
        end
        $finish;
    end

endmodule
